FILE: sv/free_block_bitmap_allocator_assert.svh
`ifndef FREE_BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH
`define FREE_BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define FBBA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fbba: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset
`define FBBA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fbba: next-cycle check failed");

`endif

FILE: sv/fbba_pkg.sv
package fbba_pkg;

	// Opcodes
	localparam logic [1:0] OP_ALLOC  = 2'd0;
	localparam logic [1:0] OP_TOGGLE = 2'd1;
	localparam logic [1:0] OP_FORMAT = 2'd2;
	localparam logic [1:0] OP_LOAD   = 2'd3;

	// Result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_FREE = 2'd1;
	localparam logic [1:0] ST_RANGE   = 2'd2;

	// Formatted bitmap pattern
	localparam logic [7:0] FILL_BYTE  = 8'hFE;
	localparam logic [7:0] FIRST_BYTE = 8'hFC;

	localparam int unsigned TB_W     = 17;
	localparam logic [TB_W-1:0] TB_RESET = 17'd65536;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] block_index;
		logic [12:0] load_index;
		logic [7:0]  load_data;
	} fbba_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] block_number;
		logic        byte_changed;
		logic [12:0] changed_index;
		logic [7:0]  changed_value;
	} fbba_out_t;

endpackage

FILE: sv/fbba_mem.sv
// Bitmap byte store: one write port, one read port, registered read data
module fbba_mem #(
	parameter int unsigned DEPTH = 8192,
	parameter int unsigned AW    = 13
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sv/fbba_engine.sv
// Sequencer around the bitmap memory: init sweep, first-fit scan,
// toggle read-modify-write, byte load and format sweep
module fbba_engine #(
	parameter int unsigned MAX_BLOCKS = 65536
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [fbba_pkg::TB_W-1:0]     cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  fbba_pkg::fbba_in_t            in_item,
	output logic                          res_valid,
	input  logic                          res_ready,
	output fbba_pkg::fbba_out_t           res
);

	localparam int unsigned DEPTH = (MAX_BLOCKS + 7) / 8;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned SW0   = $clog2(MAX_BLOCKS + 1);
	localparam int unsigned SW1   = (SW0 > fbba_pkg::TB_W) ? SW0 : fbba_pkg::TB_W;
	localparam int unsigned SW    = (SW1 > AW + 3) ? SW1 : AW + 3;

	localparam logic [SW-1:0] MAX_SZ     = SW'(MAX_BLOCKS);
	localparam logic [SW-1:0] DEPTH_SW   = SW'(DEPTH);
	localparam logic [AW:0]   LAST_ENTRY = (AW + 1)'(DEPTH - 1);

	// state codes
	localparam logic [2:0] S_INIT  = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_TG_RD = 3'd3;
	localparam logic [2:0] S_TG_WR = 3'd4;
	localparam logic [2:0] S_FMT   = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	// lowest set bit of a nonzero byte
	function automatic logic [2:0] low_bit(input logic [7:0] v);
		logic [2:0] r;
		r = 3'd0;
		for (int k = 7; k >= 0; k--) begin
			if (v[k]) begin
				r = 3'(k);
			end
		end
		return r;
	endfunction

	logic [2:0]              state_q;
	logic [fbba_pkg::TB_W-1:0] total_q;
	logic [AW:0]             ptr_q;
	logic [AW:0]             nbytes_q;
	logic                    chk_vld_q;
	logic [AW-1:0]           chk_idx_q;
	logic [SW-1:0]           size_q;
	logic [SW-1:0]           blk_q;
	fbba_pkg::fbba_out_t     res_q;

	logic [SW-1:0]  size;
	logic [SW:0]    size_rnd;
	logic [AW:0]    nbytes;
	logic [SW-1:0]  tg_blk;
	logic [SW-1:0]  ld_idx;
	logic           ld_ok;
	logic           accept;

	logic           mem_we;
	logic [AW-1:0]  mem_waddr;
	logic [7:0]     mem_wdata;
	logic           mem_re;
	logic [AW-1:0]  mem_raddr;
	logic [7:0]     mem_rdata;

	logic           found;
	logic [2:0]     fbit;
	logic [SW-1:0]  fblk;
	logic           fblk_ok;
	logic [7:0]     tg_val;
	logic           more;

	fbba_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// effective size and byte count to scan
	assign size     = (SW'(total_q) > MAX_SZ) ? MAX_SZ : SW'(total_q);
	assign size_rnd = {1'b0, size} + (SW + 1)'(7);
	assign nbytes   = size_rnd[AW+3:3];
	assign tg_blk   = SW'(in_item.block_index);
	assign ld_idx   = SW'(in_item.load_index);
	assign ld_ok    = ld_idx < DEPTH_SW;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	// scan check on the byte read last cycle
	assign found   = chk_vld_q && (mem_rdata != 8'd0);
	assign fbit    = low_bit(mem_rdata);
	assign fblk    = (SW'(chk_idx_q) << 3) | SW'(fbit);
	assign fblk_ok = fblk < size_q;
	assign more    = ptr_q < nbytes_q;
	assign tg_val  = mem_rdata ^ (8'd1 << blk_q[2:0]);

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ptr_q[AW-1:0];
		mem_wdata = fbba_pkg::FILL_BYTE;
		mem_re    = 1'b0;
		mem_raddr = ptr_q[AW-1:0];
		unique case (state_q) inside
			S_INIT, S_FMT: begin
				mem_we    = 1'b1;
				mem_wdata = (ptr_q == '0) ? fbba_pkg::FIRST_BYTE : fbba_pkg::FILL_BYTE;
			end
			S_IDLE: begin
				mem_we    = accept && (in_item.opcode == fbba_pkg::OP_LOAD) && ld_ok;
				mem_waddr = ld_idx[AW-1:0];
				mem_wdata = in_item.load_data;
			end
			S_SCAN: begin
				mem_we    = found && fblk_ok;
				mem_waddr = chk_idx_q;
				mem_wdata = mem_rdata ^ (8'd1 << fbit);
				mem_re    = !found && more;
			end
			S_TG_RD: begin
				mem_re    = 1'b1;
				mem_raddr = blk_q[AW+2:3];
			end
			S_TG_WR: begin
				mem_we    = 1'b1;
				mem_waddr = blk_q[AW+2:3];
				mem_wdata = tg_val;
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= fbba_pkg::TB_RESET;
		end else if (cfg_wr_en) begin
			total_q <= cfg_wr_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_INIT;
			ptr_q     <= '0;
			chk_vld_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_INIT: begin
					if (ptr_q == LAST_ENTRY) begin
						state_q <= S_IDLE;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (accept) begin
						unique case (in_item.opcode)
							fbba_pkg::OP_ALLOC: begin
								ptr_q     <= '0;
								chk_vld_q <= 1'b0;
								state_q   <= S_SCAN;
							end
							fbba_pkg::OP_TOGGLE: begin
								state_q <= (tg_blk >= size) ? S_DONE : S_TG_RD;
							end
							fbba_pkg::OP_FORMAT: begin
								ptr_q   <= '0;
								state_q <= S_FMT;
							end
							fbba_pkg::OP_LOAD: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (found || !more) begin
						state_q <= S_DONE;
					end else begin
						ptr_q     <= ptr_q + 1'b1;
						chk_vld_q <= 1'b1;
					end
				end
				S_TG_RD: begin
					state_q <= S_TG_WR;
				end
				S_TG_WR: begin
					state_q <= S_DONE;
				end
				S_FMT: begin
					if (ptr_q == LAST_ENTRY) begin
						state_q <= S_DONE;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item context and result payload
	always_ff @(posedge clk) begin
		unique case (state_q) inside
			S_IDLE: begin
				size_q   <= size;
				nbytes_q <= nbytes;
				blk_q    <= tg_blk;
				res_q    <= '0;
				if (accept && (in_item.opcode == fbba_pkg::OP_TOGGLE) && (tg_blk >= size)) begin
					res_q.status <= fbba_pkg::ST_RANGE;
				end
				if (accept && (in_item.opcode == fbba_pkg::OP_LOAD)) begin
					res_q.changed_index <= in_item.load_index;
					res_q.changed_value <= in_item.load_data;
				end
			end
			S_SCAN: begin
				chk_idx_q <= ptr_q[AW-1:0];
				if (found && fblk_ok) begin
					res_q.status        <= fbba_pkg::ST_OK;
					res_q.block_number  <= fblk[15:0];
					res_q.byte_changed  <= 1'b1;
					res_q.changed_index <= fblk[15:3];
					res_q.changed_value <= mem_rdata ^ (8'd1 << fbit);
				end else begin
					res_q        <= '0;
					res_q.status <= fbba_pkg::ST_NO_FREE;
				end
			end
			S_TG_WR: begin
				res_q.status        <= fbba_pkg::ST_OK;
				res_q.block_number  <= blk_q[15:0];
				res_q.byte_changed  <= 1'b1;
				res_q.changed_index <= blk_q[15:3];
				res_q.changed_value <= tg_val;
			end
			S_INIT, S_TG_RD, S_FMT, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: sv/free_block_bitmap_allocator.sv
// First-fit free-block allocator over a byte bitmap held in one synchronous
// RAM of (MAX_BLOCKS+7)/8 bytes (bit set = block free). One item is worked at
// a time. After reset the bitmap is written with the formatted pattern in an
// initialization sweep over all (MAX_BLOCKS+7)/8 bytes (8192 at the default),
// with in_ready low meanwhile; configuration writes are taken throughout.
// Allocate reads one byte per cycle from byte 0 until it finds a set bit
// or has read the last byte of the disk size. Toggle reads the byte, then
// writes it back with the bit flipped (an out-of-range toggle reads nothing),
// load writes its byte, if in range, as it is accepted, and format rewrites
// every byte. Each result is then handed to the output register. The next
// item is accepted while a finished result still waits in that register.
module free_block_bitmap_allocator #(
	parameter int unsigned MAX_BLOCKS = 65536
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [fbba_pkg::TB_W-1:0] cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  fbba_pkg::fbba_in_t        in_item,
	output logic                      out_valid,
	input  logic                      out_ready,
	output fbba_pkg::fbba_out_t       out_item
);

	logic                res_valid;
	logic                res_ready;
	fbba_pkg::fbba_out_t res;
	logic                out_valid_q;
	fbba_pkg::fbba_out_t out_item_q;

	fbba_engine #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_item     (in_item),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	// output register: free when empty or being drained
	assign res_ready = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_item_q <= res;
		end
	end

endmodule

FILE: sv/fbba_checker.sv
`include "free_block_bitmap_allocator_assert.svh"

// Port-level checks for the allocator
module fbba_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input fbba_pkg::fbba_out_t       out_item
);

	// failed results carry nothing but the status
	`FBBA_ASSERT_NOW(a_fail_zero, out_valid && (out_item.status != fbba_pkg::ST_OK), (out_item.block_number == 16'd0) && !out_item.byte_changed && (out_item.changed_index == 13'd0) && (out_item.changed_value == 8'd0))

	// a reported byte is the one holding the reported block
	`FBBA_ASSERT_NOW(a_byte_of_block, out_valid && out_item.byte_changed, (out_item.status == fbba_pkg::ST_OK) && (out_item.changed_index == out_item.block_number[15:3]))

	// one item in work at a time
	`FBBA_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

	// a stalled result holds
	`FBBA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item))

endmodule

bind free_block_bitmap_allocator fbba_checker u_fbba_checker (.*);

FILE: test/tb_free_block_bitmap_allocator.sv
module tb_free_block_bitmap_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	import fbba_pkg::*;

	// Tracks the free-block bitmap and the queue of results still owed by the block
	class bitmap_scoreboard;
		localparam int unsigned MAP_BYTES = 8192;
		localparam int unsigned SIZE_CAP = 65536;

		logic [7:0]      free_map [MAP_BYTES];
		logic [TB_W-1:0] total_blocks;
		fbba_out_t       owed_results [$];

		function void format_map();
			foreach (free_map[i]) free_map[i] = FILL_BYTE;
			free_map[0] = FIRST_BYTE;
		endfunction

		function void reset_state();
			total_blocks = TB_RESET;
			format_map();
			owed_results.delete();
		endfunction

		function void set_total(logic [TB_W-1:0] value);
			total_blocks = value;
		endfunction

		function int unsigned usable_blocks();
			return (total_blocks > SIZE_CAP) ? SIZE_CAP : total_blocks;
		endfunction

		function int pending();
			return owed_results.size();
		endfunction

		// Apply one item to the bitmap and return the result it should produce
		function fbba_out_t apply_item(fbba_in_t item);
			fbba_out_t   res;
			int unsigned size;
			int unsigned nbytes;
			int unsigned blk;
			int unsigned pos;
			int unsigned low;
			bit          done;
			res = '0;
			done = 0;
			size = usable_blocks();
			case (item.opcode)
				OP_ALLOC: begin
					res.status = ST_NO_FREE;
					nbytes = (size + 7) / 8;
					for (int unsigned i = 0; i < nbytes && !done; i++) begin
						if (free_map[i] != 8'h00) begin
							low = 0;
							for (int j = 7; j >= 0; j--) if (free_map[i][j]) low = unsigned'(j);
							blk = i * 8 + low;
							done = 1;
							// first free bit beyond the disk size means nothing usable
							if (blk < size) begin
								free_map[i][low] = 1'b0;
								res.status        = ST_OK;
								res.block_number  = blk[15:0];
								res.byte_changed  = 1'b1;
								res.changed_index = i[12:0];
								res.changed_value = free_map[i];
							end
						end
					end
				end
				OP_TOGGLE: begin
					blk = 32'(item.block_index);
					if (blk >= size) begin
						res.status = ST_RANGE;
					end else begin
						pos = blk >> 3;
						free_map[pos][blk % 8] = ~free_map[pos][blk % 8];
						res.status        = ST_OK;
						res.block_number  = blk[15:0];
						res.byte_changed  = 1'b1;
						res.changed_index = pos[12:0];
						res.changed_value = free_map[pos];
					end
				end
				OP_FORMAT: begin
					format_map();
					res.status = ST_OK;
				end
				default: begin
					// load: echoes index and data, no write-back flagged
					pos = 32'(item.load_index);
					if (pos < MAP_BYTES) free_map[pos] = item.load_data;
					res.status        = ST_OK;
					res.changed_index = item.load_index;
					res.changed_value = item.load_data;
				end
			endcase
			return res;
		endfunction

		function void note_item(fbba_in_t item);
			owed_results.push_back(apply_item(item));
		endfunction

		// Empty string when the result matches the oldest owed one
		function string check_result(fbba_out_t got);
			fbba_out_t want;
			string     msg;
			msg = "";
			if (owed_results.size() == 0)
				return $sformatf("result with none owed: status=%0d block=%0d",
					got.status, got.block_number);
			want = owed_results.pop_front();
			if (got.status !== want.status)
				msg = {msg, $sformatf(" status %0d exp %0d", got.status, want.status)};
			if (got.block_number !== want.block_number)
				msg = {msg, $sformatf(" block %0d exp %0d", got.block_number,
					want.block_number)};
			if (got.byte_changed !== want.byte_changed)
				msg = {msg, $sformatf(" changed %0b exp %0b", got.byte_changed,
					want.byte_changed)};
			if (got.changed_index !== want.changed_index)
				msg = {msg, $sformatf(" index %0d exp %0d", got.changed_index,
					want.changed_index)};
			if (got.changed_value !== want.changed_value)
				msg = {msg, $sformatf(" value %02h exp %02h", got.changed_value,
					want.changed_value)};
			return msg;
		endfunction
	endclass

	logic            clk;
	logic            arst_n;
	logic            cfg_wr_en;
	logic [TB_W-1:0] cfg_wr_data;
	logic            in_valid;
	logic            in_ready;
	fbba_in_t        in_item;
	logic            out_valid;
	logic            out_ready;
	fbba_out_t       out_item;

	bitmap_scoreboard sb;
	int unsigned      error_count;
	int unsigned      ready_hold_cycles;

	free_block_bitmap_allocator u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	task automatic report_error(string msg);
		error_count++;
		$display("MISMATCH @%0t:%s", $time, msg);
	endtask

	// Check results before noting items so a stray result is never masked
	always @(posedge clk) begin
		string msg;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				msg = sb.check_result(out_item);
				if (msg != "") report_error(msg);
			end
			if (in_valid && in_ready) sb.note_item(in_item);
		end
	end

	// Result side: random ready runs and stalls, plus a requested long hold
	initial begin
		int unsigned run_left;
		int unsigned pick;
		out_ready = 1'b0;
		run_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (ready_hold_cycles != 0) begin
				out_ready = 1'b0;
				ready_hold_cycles--;
				run_left = 0;
			end else if (run_left != 0) begin
				run_left--;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 55) begin
					out_ready = 1'b1;
					run_left = $urandom_range(0, 9);
				end else if (pick < 65) begin
					out_ready = 1'b1;
					run_left = $urandom_range(30, 80);
				end else if (pick < 92) begin
					out_ready = 1'b0;
					run_left = $urandom_range(0, 2);
				end else begin
					out_ready = 1'b0;
					run_left = $urandom_range(10, 50);
				end
			end
		end
	end

	function automatic int unsigned rand_gap();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 45) return 0;
		if (pick < 80) return $urandom_range(1, 3);
		if (pick < 95) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic fbba_in_t make_item(logic [1:0] op, logic [15:0] blk,
		logic [12:0] lidx, logic [7:0] ldata);
		fbba_in_t item;
		item.opcode      = op;
		item.block_index = blk;
		item.load_index  = lidx;
		item.load_data   = ldata;
		return item;
	endfunction

	// Random item; unused fields carry junk. Toggles and loads favor the
	// low bitmap region so that they interact with allocations.
	function automatic fbba_in_t random_item();
		fbba_in_t    item;
		int unsigned pick;
		int unsigned size;
		item.block_index = 16'($urandom);
		item.load_index  = 13'($urandom);
		item.load_data   = 8'($urandom);
		size = sb.usable_blocks();
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			item.opcode = OP_ALLOC;
		end else if (pick < 70) begin
			item.opcode = OP_TOGGLE;
			pick = $urandom_range(0, 9);
			if (pick < 6)
				item.block_index = 16'($urandom_range(0, 63));
			else if (pick < 8)
				item.block_index = 16'(size + $urandom_range(0, 3) - 2);
		end else if (pick < 95) begin
			item.opcode = OP_LOAD;
			if ($urandom_range(0, 9) < 7) item.load_index = 13'($urandom_range(0, 7));
		end else begin
			item.opcode = OP_FORMAT;
		end
		return item;
	endfunction

	// Offer one item, hold it until taken, then idle for the given gap
	task automatic send_item(fbba_in_t item, int unsigned gap);
		in_item  = item;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic send_op(logic [1:0] op, logic [15:0] blk, logic [12:0] lidx,
		logic [7:0] ldata, int unsigned gap);
		send_item(make_item(op, blk, lidx, ldata), gap);
	endtask

	// Stop offering and wait until every owed result is back
	task automatic drain();
		in_valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	task automatic write_total(logic [TB_W-1:0] value);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = value;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		sb.set_total(value);
	endtask

	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		logic [TB_W-1:0] phase_total [5];
		sb = new();
		sb.reset_state();
		error_count = 0;
		ready_hold_cycles = 0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		in_item = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed, reset size, back to back
		send_op(OP_ALLOC, 0, 0, 0, 0);
		send_op(OP_ALLOC, 0, 0, 0, 0);
		send_op(OP_TOGGLE, 16'd2, 0, 0, 0);
		send_op(OP_TOGGLE, 16'd0, 0, 0, 0);
		send_op(OP_ALLOC, 16'hFFFF, 13'h1FFF, 8'hFF, 0);
		send_op(OP_TOGGLE, 16'hFFFF, 0, 0, 0);
		send_op(OP_LOAD, 0, 13'h1FFF, 8'hFF, 0);
		send_op(OP_LOAD, 0, 13'd0, 8'h00, 0);
		send_op(OP_LOAD, 0, 13'd1, 8'h00, 0);
		send_op(OP_ALLOC, 0, 0, 0, 0);
		send_op(OP_LOAD, 16'h5555, 13'h1555, 8'hAA, 0);
		send_op(OP_LOAD, 16'hAAAA, 13'h0AAA, 8'h55, 0);
		send_op(OP_FORMAT, 0, 0, 0, 0);
		send_op(OP_ALLOC, 0, 0, 0, rand_gap());

		// One block only: the first free bit lies beyond it
		drain();
		write_total(17'd1);
		send_op(OP_ALLOC, 0, 0, 0, rand_gap());
		send_op(OP_TOGGLE, 16'd0, 0, 0, rand_gap());
		send_op(OP_TOGGLE, 16'd1, 0, 0, rand_gap());
		send_op(OP_TOGGLE, 16'hFFFF, 0, 0, rand_gap());
		send_op(OP_ALLOC, 0, 0, 0, rand_gap());
		send_op(OP_ALLOC, 0, 0, 0, rand_gap());

		// Size above the cap
		drain();
		write_total({TB_W{1'b1}});
		send_op(OP_TOGGLE, 16'hFFFF, 0, 0, rand_gap());
		send_op(OP_ALLOC, 0, 0, 0, rand_gap());

		// No blocks at all
		drain();
		write_total('0);
		send_op(OP_ALLOC, 0, 0, 0, rand_gap());
		send_op(OP_TOGGLE, 16'd0, 0, 0, rand_gap());

		// Random phases, each at its own disk size
		phase_total[0] = TB_RESET;
		phase_total[1] = {TB_W{1'b1}};
		phase_total[2] = TB_W'($urandom_range(1, 48));
		phase_total[3] = TB_W'($urandom_range(1, 131071));
		phase_total[4] = TB_W'($urandom_range(49, 2000));
		for (int p = 0; p < 5; p++) begin
			drain();
			write_total(phase_total[p]);
			if (p == 0) begin
				// hold results back while items keep coming so the block backs up
				ready_hold_cycles = 300;
				repeat (10) send_item(random_item(), 0);
			end
			repeat (15) send_item(random_item(), rand_gap());
		end

		drain();
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
